FILE: sv/refcounted_address_table_assert.svh
// Assertion macros for the reference-counted address table.
`ifndef REFCOUNTED_ADDRESS_TABLE_ASSERT_SVH
`define REFCOUNTED_ADDRESS_TABLE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define RCAT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition implies another on the following edge.
`define RCAT_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error(msg);

`endif

FILE: sv/rcat_pkg.sv
// Types, codes and defaults shared by the reference-counted address table.
package rcat_pkg;

    localparam int RCAT_ENTRIES_DEF = 16;

    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_FIND   = 3'd2;
    localparam logic [2:0] MODE_GET    = 3'd3;
    localparam logic [2:0] MODE_SET    = 3'd4;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
    localparam logic [2:0] STAT_BAD_STATE = 3'd2;
    localparam logic [2:0] STAT_FULL      = 3'd3;
    localparam logic [2:0] STAT_BAD_ARG   = 3'd4;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [63:0] addr;
        logic [63:0] count;
    } rcat_entry_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_EXEC
    } rcat_state_t;

endpackage

FILE: sv/rcat_mem.sv
// Entry memory: one write port, one read port, registered read data.
module rcat_mem
    import rcat_pkg::*;
#(
    parameter int DEPTH = RCAT_ENTRIES_DEF,
    parameter int WIDTH = $bits(rcat_entry_t)
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/refcounted_address_table.sv
// Top level of the reference-counted address table.
// Each request beat is looked up by a scan of the entry memory: one record is
// read per cycle through the single read port, and the scan closes once the
// registered read data of the last record has been examined. The scan finds the
// matching record and the lowest free record; the write-back state then modifies
// and writes the record back and loads the result, and the block returns to idle.
// No new request is accepted before the last one has been written back. Requests
// rejected on their arguments skip the scan and go straight to the write-back.
// The write-back waits while an earlier result is still held on the master side.
// After reset the block clears the valid flag of every record, one per cycle,
// and accepts no request until this is done. A result waiting on the master side
// does not stop the next request from being accepted and scanned.
module refcounted_address_table
    import rcat_pkg::*;
#(
    parameter int ENTRIES = RCAT_ENTRIES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode[2:0], space_key[34:3], virt_addr[98:35], count_value[162:99], zero fill
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], addr_out[66:3], count_out[130:67], live_entries[135:131]
    output logic [135:0] m_tdata
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = IW + 1;
    localparam int LW = $clog2(ENTRIES + 1);
    localparam int EW = $bits(rcat_entry_t);

    rcat_state_t state_reg, state_next;

    logic [CW-1:0] scan_cnt_reg, scan_cnt_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic          found_reg, found_next;
    logic          free_found_reg, free_found_next;
    logic [IW-1:0] match_slot_reg, match_slot_next;
    logic [IW-1:0] free_slot_reg, free_slot_next;
    rcat_entry_t   match_reg, match_next;
    logic [2:0]    mode_reg, mode_next;
    logic [31:0]   key_reg, key_next;
    logic [63:0]   vaddr_reg, vaddr_next;
    logic [63:0]   cval_reg, cval_next;
    logic          bad_arg_reg, bad_arg_next;
    logic [LW-1:0] live_reg, live_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [135:0]  m_tdata_reg, m_tdata_next;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    rcat_entry_t   mem_wdata;
    logic [IW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;
    rcat_entry_t   rd_entry;

    logic          s_accept;
    logic          out_free;
    logic          scan_done;
    logic          clear_done;
    logic [2:0]    in_mode;
    logic [31:0]   in_key;
    logic [63:0]   in_vaddr;
    logic [63:0]   in_cval;
    logic          in_bad_arg;
    logic [2:0]    ex_status;
    logic [63:0]   ex_addr;
    logic [63:0]   ex_count;
    logic          ex_we;
    logic [IW-1:0] ex_waddr;
    rcat_entry_t   ex_wdata;
    logic [LW-1:0] ex_live;
    logic [63:0]   cnt_dec;
    logic [LW+4:0] live_ext;

    rcat_mem #(
        .DEPTH(ENTRIES),
        .WIDTH(EW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign rd_entry   = rcat_entry_t'(mem_rdata);
    assign in_mode    = s_tdata[2:0];
    assign in_key     = s_tdata[34:3];
    assign in_vaddr   = s_tdata[98:35];
    assign in_cval    = s_tdata[162:99];
    assign in_bad_arg = (in_mode > MODE_SET) || (in_key == 32'd0) ||
                        ((in_mode == MODE_SET) && (in_cval == 64'd0));
    assign s_tready   = (state_reg == S_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign scan_done  = (scan_cnt_reg == CW'(ENTRIES)) && !rd_pend_reg;
    assign clear_done = (scan_cnt_reg == CW'(ENTRIES - 1));
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clear_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    state_next = in_bad_arg ? S_EXEC : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        ex_status = STAT_OK;
        ex_addr   = 64'd0;
        ex_count  = 64'd0;
        ex_we     = 1'b0;
        ex_waddr  = match_slot_reg;
        ex_wdata  = match_reg;
        ex_live   = live_reg;
        cnt_dec   = match_reg.count - 64'd1;
        if (bad_arg_reg) begin
            ex_status = STAT_BAD_ARG;
        end else if (mode_reg == MODE_ADD) begin
            if (found_reg) begin
                if ((match_reg.count == '1) || (match_reg.addr != vaddr_reg)) begin
                    ex_status = STAT_BAD_STATE;
                end else begin
                    ex_we          = 1'b1;
                    ex_wdata.count = match_reg.count + 64'd1;
                end
            end else if (!free_found_reg) begin
                ex_status = STAT_FULL;
            end else begin
                ex_we          = 1'b1;
                ex_waddr       = free_slot_reg;
                ex_wdata.valid = 1'b1;
                ex_wdata.key   = key_reg;
                ex_wdata.addr  = vaddr_reg;
                ex_wdata.count = 64'd1;
                ex_live        = live_reg + LW'(1);
            end
        end else if (!found_reg) begin
            ex_status = STAT_NOT_FOUND;
        end else begin
            case (mode_reg)
                MODE_REMOVE: begin
                    ex_we          = 1'b1;
                    ex_wdata.count = cnt_dec;
                    if (cnt_dec == 64'd0) begin
                        ex_wdata.valid = 1'b0;
                        ex_wdata.addr  = 64'd0;
                        if (live_reg != LW'(0)) begin
                            ex_live = live_reg - LW'(1);
                        end
                    end
                end
                MODE_FIND: begin
                    ex_addr = match_reg.addr;
                end
                MODE_GET: begin
                    ex_count = match_reg.count;
                end
                MODE_SET: begin
                    ex_we          = 1'b1;
                    ex_wdata.count = cval_reg;
                end
                default: begin
                    ex_status = STAT_BAD_ARG;
                end
            endcase
        end
        live_ext = (LW + 5)'(ex_live);
    end

    always_comb begin
        scan_cnt_next   = scan_cnt_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        match_slot_next = match_slot_reg;
        free_slot_next  = free_slot_reg;
        match_next      = match_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        vaddr_next      = vaddr_reg;
        cval_next       = cval_reg;
        bad_arg_next    = bad_arg_reg;
        live_next       = live_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        mem_we          = 1'b0;
        mem_waddr       = scan_cnt_reg[IW-1:0];
        mem_wdata       = '0;
        mem_raddr       = scan_cnt_reg[IW-1:0];
        case (state_reg)
            S_CLEAR: begin
                mem_we        = 1'b1;
                scan_cnt_next = clear_done ? '0 : scan_cnt_reg + CW'(1);
            end
            S_IDLE: begin
                if (s_accept) begin
                    mode_next       = in_mode;
                    key_next        = in_key;
                    vaddr_next      = in_vaddr;
                    cval_next       = in_cval;
                    bad_arg_next    = in_bad_arg;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    scan_cnt_next   = '0;
                end
            end
            S_SCAN: begin
                if (scan_cnt_reg != CW'(ENTRIES)) begin
                    rd_pend_next  = 1'b1;
                    rd_idx_next   = scan_cnt_reg[IW-1:0];
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                end
                if (rd_pend_reg) begin
                    if (rd_entry.valid && (rd_entry.key == key_reg) && !found_reg) begin
                        found_next      = 1'b1;
                        match_slot_next = rd_idx_reg;
                        match_next      = rd_entry;
                    end
                    if (!rd_entry.valid && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_slot_next  = rd_idx_reg;
                    end
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    mem_we        = ex_we;
                    mem_waddr     = ex_waddr;
                    mem_wdata     = ex_wdata;
                    live_next     = ex_live;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {live_ext[4:0], ex_count, ex_addr, ex_status};
                end
            end
            default: begin
                scan_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            scan_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
            live_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            rd_pend_reg  <= rd_pend_next;
            live_reg     <= live_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        found_reg      <= found_next;
        free_found_reg <= free_found_next;
        match_slot_reg <= match_slot_next;
        free_slot_reg  <= free_slot_next;
        match_reg      <= match_next;
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        vaddr_reg      <= vaddr_next;
        cval_reg       <= cval_next;
        bad_arg_reg    <= bad_arg_next;
        m_tdata_reg    <= m_tdata_next;
    end

`include "refcounted_address_table_assert.svh"

    `RCAT_ASSERT(a_live_bound, live_reg <= LW'(ENTRIES), "live count exceeds table size")
    `RCAT_ASSERT(a_live_exec, !$stable(live_reg) |-> $past(state_reg == S_EXEC), "live count moved outside write-back")
    `RCAT_ASSERT(a_result_exec, (m_tvalid_reg && !$past(m_tvalid_reg)) |-> $past(state_reg == S_EXEC), "result raised without write-back")
    `RCAT_ASSERT_NEXT(a_scan_start, s_accept && !in_bad_arg, state_reg == S_SCAN && scan_cnt_reg == '0, "scan did not start from first record")

endmodule
